### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

### src/dts_pkg.sv
// shared types and constants of the date sorter
`default_nettype none

package dts_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 16;
  localparam int KEY_W   = DAY_W + MONTH_W + YEAR_W;

  typedef logic [KEY_W-1:0] date_key_t;

  typedef struct packed {
    logic      valid;
    logic      grt;
    date_key_t key;
  } dts_link_t;

  typedef struct packed {
    logic      ins;
    logic      shift;
    date_key_t key_new;
  } dts_ctrl_t;

endpackage

`default_nettype wire

### src/dts_if.sv
// valid/ready channel interfaces for dates in and sorted dates out
`default_nettype none

interface dts_in_if;
  import dts_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_in;
  logic [MONTH_W-1:0] month_in;
  logic [YEAR_W-1:0]  year_in;
  logic               last_in;

  modport source (output valid, day_in, month_in, year_in, last_in, input ready);
  modport sink (input valid, day_in, month_in, year_in, last_in, output ready);
endinterface

interface dts_out_if;
  import dts_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day_out;
  logic [MONTH_W-1:0] month_out;
  logic [YEAR_W-1:0]  year_out;
  logic               last_out;
  logic               overflow;

  modport source (output valid, day_out, month_out, year_out, last_out, overflow,
                  input ready);
  modport sink (input valid, day_out, month_out, year_out, last_out, overflow,
                output ready);
endinterface

`default_nettype wire

### src/dts_cell.sv
// one sorting cell: holds a date, inserts in order and shifts toward the head
`default_nettype none

module dts_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dts_pkg::dts_ctrl_t ctrl,
  input  wire dts_pkg::dts_link_t left,
  input  wire dts_pkg::dts_link_t right,
  output dts_pkg::dts_link_t     link
);
  import dts_pkg::*;

  logic      valid;
  date_key_t key;
  logic      grt;

  // an empty cell counts as greater so the new date lands at the tail
  assign grt = !valid || (key > ctrl.key_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end else if (ctrl.ins && grt) begin
      valid <= valid | left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= right.key;
    end else if (ctrl.ins && grt) begin
      key <= left.grt ? left.key : ctrl.key_new;
    end
  end

  assign link.valid = valid;
  assign link.grt   = grt;
  assign link.key   = key;

endmodule

`default_nettype wire

### src/date_sorter_top.sv
// date sorter: insertion chain of compare cells, sorted drain on the last item
// the first sorted result is offered in the cycle after the last item is taken
// throughput: one date inserted per cycle while collecting and not full; one result per cycle
//   while draining and the output is ready, input held off until the batch has left
// reset clears the cell valid bits, the drain flag and the overflow flag at once
`default_nettype none

module date_sorter_top #(
  parameter int MAX_DATES = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  dts_in_if.sink    item_in,
  dts_out_if.source item_out
);
  import dts_pkg::*;

  dts_link_t links [MAX_DATES];
  dts_ctrl_t ctrl;
  logic      draining;
  logic      overflow_seen;
  logic      full;
  logic      in_acc;
  logic      out_acc;
  logic      batch_done;

  assign full       = links[MAX_DATES-1].valid;
  assign in_acc     = item_in.valid && item_in.ready;
  assign out_acc    = item_out.valid && item_out.ready;
  assign batch_done = out_acc && item_out.last_out;

  assign item_in.ready = !draining;

  assign ctrl.ins     = in_acc && !full;
  assign ctrl.shift   = out_acc;
  assign ctrl.key_new = {item_in.year_in, item_in.month_in, item_in.day_in};

  for (genvar i = 0; i < MAX_DATES; i++) begin : g_cell
    dts_link_t left;
    dts_link_t right;

    if (i == 0) begin : g_head
      assign left = '{valid: 1'b1, grt: 1'b0, key: '0};
    end else begin : g_mid
      assign left = links[i-1];
    end

    if (i == MAX_DATES - 1) begin : g_tail
      assign right = '{valid: 1'b0, grt: 1'b1, key: '0};
    end else begin : g_body
      assign right = links[i+1];
    end

    dts_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .link  (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else if (in_acc && item_in.last_in) begin
      draining <= 1'b1;
    end else if (batch_done) begin
      draining <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
    end else if (in_acc && full) begin
      overflow_seen <= 1'b1;
    end else if (batch_done) begin
      overflow_seen <= 1'b0;
    end
  end

  assign item_out.valid     = draining && links[0].valid;
  assign item_out.day_out   = links[0].key[DAY_W-1:0];
  assign item_out.month_out = links[0].key[DAY_W+MONTH_W-1:DAY_W];
  assign item_out.year_out  = links[0].key[KEY_W-1:DAY_W+MONTH_W];
  assign item_out.last_out  = !links[1].valid;
  assign item_out.overflow  = overflow_seen;

endmodule

`default_nettype wire

### src/dts_checker.sv
// port-level checks of the date sorter, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module dts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [24:0] out_data,
  input wire logic        out_last,
  input wire logic        out_overflow
);

  // stalled result holds its value
  `ASSERT_PROP(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // input is held off while a batch drains
  `ASSERT_NEVER(a_no_in_during_drain, out_valid && in_ready)

  // a last item starts the drain right away
  `ASSERT_PROP(a_drain_starts, in_valid && in_ready && in_last |=> out_valid)

  // overflow flag stays fixed across a batch
  `ASSERT_PROP(a_ovf_steady, out_valid && out_ready && !out_last |=> out_valid && out_overflow == $past(out_overflow))

endmodule

bind date_sorter_top dts_checker u_dts_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .in_last      (item_in.last_in),
  .out_valid    (item_out.valid),
  .out_ready    (item_out.ready),
  .out_data     ({item_out.year_out, item_out.month_out, item_out.day_out}),
  .out_last     (item_out.last_out),
  .out_overflow (item_out.overflow)
);

`default_nettype wire
